>>> sv/skvm_pkg.sv
// Package with the shared types and constants of the sorted key/value map.
`timescale 1ns / 1ps
package skvm_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 2;
  localparam int ENTRY_W  = KEY_W + VAL_W;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_KEY   = 1'd0,
    CFG_ROOT_VALUE = 1'd1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_INSERT,
    ST_REMOVE,
    ST_DONE
  } state_e;

endpackage

>>> sv/skvm_if.sv
// Request and response channel interfaces of the sorted key/value map.
`timescale 1ns / 1ps
interface skvm_in_if;
  logic                       valid;
  logic                       ready;
  logic [skvm_pkg::REQ_W-1:0] req_type;
  logic [skvm_pkg::KEY_W-1:0] key;
  logic [skvm_pkg::VAL_W-1:0] new_value;

  modport source (output valid, req_type, key, new_value, input ready);
  modport sink (input valid, req_type, key, new_value, output ready);
endinterface

interface skvm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [skvm_pkg::VAL_W-1:0] read_value;
  logic                       status;

  modport source (output valid, found, read_value, status, input ready);
  modport sink (input valid, found, read_value, status, output ready);
endinterface

>>> sv/sorted_key_value_map.sv
// Sorted key/value map: entries kept in key order in one RAM, found by binary search.
// A root-key lookup, a request of the reserved type or a delete of key zero goes straight to done.
// Other requests run a binary search of up to 11 steps, each a probe state and a compare state;
// an add that inserts or a delete that removes then moves entries one by one in the insert or remove state.
// Requests are taken one at a time, only in the idle state; the done state waits for the response register.
// Reset clears the entry count, the root registers and the handshakes; the RAM is not cleared.
`timescale 1ns / 1ps
module sorted_key_value_map (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  skvm_in_if.sink                           req_i,
  skvm_out_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [skvm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [skvm_pkg::KEY_W-1:0]        cfg_wdata_i
);

  skvm_pkg::state_e state_q, state_d;

  logic [skvm_pkg::KEY_W-1:0]   root_key_q;
  logic [skvm_pkg::VAL_W-1:0]   root_value_q;
  logic [skvm_pkg::CNT_W-1:0]   count_q, count_d;
  logic [skvm_pkg::REQ_W-1:0]   req_q, req_d;
  logic [skvm_pkg::KEY_W-1:0]   key_q, key_d;
  logic [skvm_pkg::VAL_W-1:0]   val_q, val_d;
  logic [skvm_pkg::CNT_W-1:0]   lo_q, lo_d;
  logic [skvm_pkg::CNT_W-1:0]   hi_q, hi_d;
  logic [skvm_pkg::CNT_W-1:0]   mid_q, mid_d;
  logic [skvm_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic                         hit_q, hit_d;
  logic [skvm_pkg::VAL_W-1:0]   hit_val_q, hit_val_d;
  logic                         pend_q, pend_d;
  logic [skvm_pkg::CNT_W-1:0]   pend_addr_q, pend_addr_d;
  logic                         res_found_q, res_found_d;
  logic [skvm_pkg::VAL_W-1:0]   res_val_q, res_val_d;
  logic                         res_status_q, res_status_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_found_q;
  logic [skvm_pkg::VAL_W-1:0]   out_val_q;
  logic                         out_status_q;

  logic                         accept;
  logic                         search_done;
  logic                         full;
  logic                         out_load;
  logic [skvm_pkg::CNT_W-1:0]   mid_calc;
  logic [skvm_pkg::KEY_W-1:0]   rd_key;
  logic [skvm_pkg::VAL_W-1:0]   rd_val;

  logic                         ram_we;
  logic [skvm_pkg::IDX_W-1:0]   ram_waddr;
  logic [skvm_pkg::ENTRY_W-1:0] ram_wdata;
  logic [skvm_pkg::IDX_W-1:0]   ram_raddr;
  logic [skvm_pkg::ENTRY_W-1:0] ram_rdata;

  assign accept      = req_i.valid & req_i.ready;
  assign search_done = lo_q >= hi_q;
  assign full        = count_q == skvm_pkg::CNT_W'(skvm_pkg::CAPACITY);
  assign mid_calc    = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_key      = ram_rdata[skvm_pkg::ENTRY_W-1:skvm_pkg::VAL_W];
  assign rd_val      = ram_rdata[skvm_pkg::VAL_W-1:0];
  assign out_load    = (state_q == skvm_pkg::ST_DONE) && (!out_valid_q || rsp_o.ready);

  skvm_ram #(
    .WIDTH (skvm_pkg::ENTRY_W),
    .DEPTH (skvm_pkg::CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skvm_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (req_i.req_type == skvm_pkg::REQ_LOOKUP && req_i.key == root_key_q) begin
            state_d = skvm_pkg::ST_DONE;
          end else if (req_i.req_type == skvm_pkg::REQ_LOOKUP ||
                       req_i.req_type == skvm_pkg::REQ_ADD ||
                       (req_i.req_type == skvm_pkg::REQ_DELETE && req_i.key != '0)) begin
            state_d = skvm_pkg::ST_PROBE;
          end else begin
            state_d = skvm_pkg::ST_DONE;
          end
        end
      end
      skvm_pkg::ST_PROBE: begin
        if (!search_done) begin
          state_d = skvm_pkg::ST_CMP;
        end else begin
          unique case (skvm_pkg::req_e'(req_q))
            skvm_pkg::REQ_ADD:    state_d = (hit_q || full) ? skvm_pkg::ST_DONE
                                                             : skvm_pkg::ST_INSERT;
            skvm_pkg::REQ_DELETE: state_d = hit_q ? skvm_pkg::ST_REMOVE : skvm_pkg::ST_DONE;
            default:              state_d = skvm_pkg::ST_DONE;
          endcase
        end
      end
      skvm_pkg::ST_CMP: state_d = skvm_pkg::ST_PROBE;
      skvm_pkg::ST_INSERT: begin
        if (idx_q <= lo_q && !pend_q) begin
          state_d = skvm_pkg::ST_DONE;
        end
      end
      skvm_pkg::ST_REMOVE: begin
        if (idx_q + 1'b1 >= count_q && !pend_q) begin
          state_d = skvm_pkg::ST_DONE;
        end
      end
      skvm_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = skvm_pkg::ST_IDLE;
        end
      end
      default: state_d = skvm_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    count_d      = count_q;
    req_d        = req_q;
    key_d        = key_q;
    val_d        = val_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    hit_val_d    = hit_val_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    res_found_d  = res_found_q;
    res_val_d    = res_val_q;
    res_status_d = res_status_q;
    unique case (state_q)
      skvm_pkg::ST_IDLE: begin
        if (accept) begin
          req_d        = req_i.req_type;
          key_d        = req_i.key;
          val_d        = req_i.new_value;
          lo_d         = '0;
          hi_d         = count_q;
          hit_d        = 1'b0;
          res_found_d  = 1'b0;
          res_val_d    = '0;
          res_status_d = 1'b0;
          if (req_i.req_type == skvm_pkg::REQ_LOOKUP && req_i.key == root_key_q) begin
            res_found_d = 1'b1;
            res_val_d   = root_value_q;
          end
        end
      end
      skvm_pkg::ST_PROBE: begin
        if (!search_done) begin
          mid_d = mid_calc;
        end else begin
          unique case (skvm_pkg::req_e'(req_q))
            skvm_pkg::REQ_LOOKUP: begin
              res_found_d = hit_q;
              res_val_d   = hit_q ? hit_val_q : '0;
            end
            skvm_pkg::REQ_ADD: begin
              res_found_d  = hit_q;
              res_status_d = !hit_q && full;
              idx_d        = count_q;
            end
            skvm_pkg::REQ_DELETE: begin
              res_found_d = hit_q;
              idx_d       = lo_q;
            end
            default: begin
              res_found_d = 1'b0;
            end
          endcase
        end
      end
      skvm_pkg::ST_CMP: begin
        if (rd_key < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if (rd_key == key_q) begin
          hit_d     = 1'b1;
          hit_val_d = rd_val;
        end
      end
      skvm_pkg::ST_INSERT: begin
        if (idx_q > lo_q) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_q - 1'b1;
        end else if (!pend_q) begin
          count_d = count_q + 1'b1;
        end
      end
      skvm_pkg::ST_REMOVE: begin
        if (idx_q + 1'b1 < count_q) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
        end
      end
      skvm_pkg::ST_DONE: begin
        res_found_d = res_found_q;
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Outputs: RAM control and handshakes.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_q[skvm_pkg::IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = mid_calc[skvm_pkg::IDX_W-1:0];
    unique case (state_q)
      skvm_pkg::ST_PROBE: begin
        if (search_done && skvm_pkg::req_e'(req_q) == skvm_pkg::REQ_ADD && hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = lo_q[skvm_pkg::IDX_W-1:0];
          ram_wdata = {key_q, val_q};
        end
      end
      skvm_pkg::ST_INSERT: begin
        ram_raddr = idx_q[skvm_pkg::IDX_W-1:0] - 1'b1;
        if (pend_q) begin
          ram_we = 1'b1;
        end else if (idx_q <= lo_q) begin
          ram_we    = 1'b1;
          ram_waddr = lo_q[skvm_pkg::IDX_W-1:0];
          ram_wdata = {key_q, val_q};
        end
      end
      skvm_pkg::ST_REMOVE: begin
        ram_raddr = idx_q[skvm_pkg::IDX_W-1:0] + 1'b1;
        ram_we    = pend_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign req_i.ready = state_q == skvm_pkg::ST_IDLE;

  always_comb begin
    out_valid_d = out_valid_q & ~rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_val_q;
  assign rsp_o.status     = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= skvm_pkg::ST_IDLE;
      count_q      <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      root_key_q   <= '0;
      root_value_q <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (skvm_pkg::cfg_e'(cfg_idx_i))
          skvm_pkg::CFG_ROOT_KEY:   root_key_q   <= cfg_wdata_i;
          skvm_pkg::CFG_ROOT_VALUE: root_value_q <= cfg_wdata_i;
          default:                  root_key_q   <= root_key_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    val_q        <= val_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    hit_val_q    <= hit_val_d;
    pend_addr_q  <= pend_addr_d;
    res_found_q  <= res_found_d;
    res_val_q    <= res_val_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_val_q    <= res_val_q;
      out_status_q <= res_status_q;
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skvm_pkg::CNT_W'(skvm_pkg::CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skvm_pkg::ST_IDLE || state_q == skvm_pkg::ST_DONE) |-> !ram_we)
    else $error("RAM written outside of a request.");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skvm_pkg::ST_CMP) |-> (lo_q < hi_q && mid_q < count_q))
    else $error("Binary search probe out of range.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == skvm_pkg::ST_DONE))
    else $error("Result transfer started without a finished request.");
`endif

endmodule

>>> sv/skvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module skvm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/sorted_key_value_map_tb.sv
// Self-checking testbench for the sorted key/value map with a predicting scoreboard.
`timescale 1ns / 1ps
module sorted_key_value_map_tb;

  localparam logic [skvm_pkg::REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam logic                       STATUS_FULL  = 1'b1;
  localparam int                         POOL_SIZE    = 40;
  localparam int                         FILL_COUNT   = 230;

  typedef struct packed {
    logic                       found;
    logic [skvm_pkg::VAL_W-1:0] read_value;
    logic                       status;
  } map_rsp_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} rdy_mode_e;

  class map_tracker;
    logic [skvm_pkg::KEY_W-1:0] key_mem [skvm_pkg::CAPACITY];
    logic [skvm_pkg::VAL_W-1:0] val_mem [skvm_pkg::CAPACITY];
    int unsigned                entries;
    logic [skvm_pkg::KEY_W-1:0] root_key;
    logic [skvm_pkg::VAL_W-1:0] root_value;
    map_rsp_t                   pending_rsp_q [$];
    int unsigned                n_req, n_hit, n_insert, n_update, n_full, n_delete, peak;
    int unsigned                n_checked, errors;

    function new();
      entries    = 0;
      root_key   = '0;
      root_value = '0;
    endfunction

    function void write_reg(skvm_pkg::cfg_e idx, logic [skvm_pkg::KEY_W-1:0] data);
      if (idx == skvm_pkg::CFG_ROOT_KEY) begin
        root_key = data;
      end else begin
        root_value = data;
      end
    endfunction

    function int unsigned lower_bound(logic [skvm_pkg::KEY_W-1:0] k);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = entries;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (key_mem[mid] < k) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      return lo;
    endfunction

    function void note_request(logic [skvm_pkg::REQ_W-1:0] rt, logic [skvm_pkg::KEY_W-1:0] k,
                               logic [skvm_pkg::VAL_W-1:0] v);
      map_rsp_t    r;
      int unsigned pos;
      bit          hit;
      r = '0;
      n_req++;
      pos = lower_bound(k);
      hit = (pos < entries) && (key_mem[pos] == k);
      unique case (rt)
        skvm_pkg::REQ_LOOKUP: begin
          if (k == root_key) begin
            r.found      = 1'b1;
            r.read_value = root_value;
          end else if (hit) begin
            r.found      = 1'b1;
            r.read_value = val_mem[pos];
          end
          if (r.found) n_hit++;
        end
        skvm_pkg::REQ_ADD: begin
          if (hit) begin
            r.found      = 1'b1;
            val_mem[pos] = v;
            n_update++;
          end else if (entries >= skvm_pkg::CAPACITY) begin
            r.status = STATUS_FULL;
            n_full++;
          end else begin
            for (int unsigned i = entries; i > pos; i--) begin
              key_mem[i] = key_mem[i-1];
              val_mem[i] = val_mem[i-1];
            end
            key_mem[pos] = k;
            val_mem[pos] = v;
            entries++;
            n_insert++;
            if (entries > peak) peak = entries;
          end
        end
        skvm_pkg::REQ_DELETE: begin
          if (k != '0 && hit) begin
            r.found = 1'b1;
            for (int unsigned i = pos; i + 1 < entries; i++) begin
              key_mem[i] = key_mem[i+1];
              val_mem[i] = val_mem[i+1];
            end
            entries--;
            n_delete++;
          end
        end
        default: begin
        end
      endcase
      pending_rsp_q.push_back(r);
    endfunction

    function void check_response(logic f, logic [skvm_pkg::VAL_W-1:0] rv, logic st);
      map_rsp_t want;
      n_checked++;
      if (pending_rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: response %0d arrived with no request outstanding",
                                   n_checked);
        return;
      end
      want = pending_rsp_q.pop_front();
      if (want.found !== f || want.read_value !== rv || want.status !== st) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: response %0d expected found=%0b value=%08h status=%0b",
                   n_checked, want.found, want.read_value, want.status);
          $display("       got found=%0b value=%08h status=%0b", f, rv, st);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [skvm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [skvm_pkg::KEY_W-1:0]     cfg_wdata_i;

  skvm_in_if  req_if ();
  skvm_out_if rsp_if ();

  map_tracker                 sb = new();
  logic [skvm_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  logic [skvm_pkg::KEY_W-1:0] fill_keys [$];
  int unsigned                burst_left;
  int unsigned                root_moves;
  int unsigned                rsp_cycle;
  rdy_mode_e                  stall_mode;

  sorted_key_value_map DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rsp_cycle % 113 == 0) stall_mode = rdy_mode_e'($urandom_range(0, 3));
    rsp_cycle++;
    unique case (stall_mode)
      RDY_ALWAYS: rsp_if.ready <= 1'b1;
      RDY_COIN:   rsp_if.ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: rsp_if.ready <= (rsp_cycle % 5 == 0);
      default:    rsp_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_response(rsp_if.found, rsp_if.read_value, rsp_if.status);
    end
  end

  task automatic send_req(logic [skvm_pkg::REQ_W-1:0] rt, logic [skvm_pkg::KEY_W-1:0] k,
                          logic [skvm_pkg::VAL_W-1:0] v);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= rt;
    req_if.key       <= k;
    req_if.new_value <= v;
    burst_left--;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(rt, k, v);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending_rsp_q.size() != 0);
  endtask

  task automatic set_root(logic [skvm_pkg::KEY_W-1:0] k, logic [skvm_pkg::VAL_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= skvm_pkg::CFG_ROOT_KEY;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    sb.write_reg(skvm_pkg::CFG_ROOT_KEY, k);
    cfg_idx_i   <= skvm_pkg::CFG_ROOT_VALUE;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_reg(skvm_pkg::CFG_ROOT_VALUE, v);
    cfg_we_i <= 1'b0;
    root_moves++;
    @(posedge clk_i);
  endtask

  function automatic logic [skvm_pkg::KEY_W-1:0] pick_key(bit use_fill);
    if (use_fill && fill_keys.size() != 0 && $urandom_range(0, 1) == 1) begin
      return fill_keys[$urandom_range(0, fill_keys.size() - 1)];
    end
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic run_mixed(int unsigned n, int unsigned w_lookup, int unsigned w_add,
                           int unsigned w_delete, bit use_fill);
    int unsigned                r;
    logic [skvm_pkg::REQ_W-1:0] rt;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_lookup) begin
        rt = skvm_pkg::REQ_LOOKUP;
      end else if (r < w_lookup + w_add) begin
        rt = skvm_pkg::REQ_ADD;
      end else if (r < w_lookup + w_add + w_delete) begin
        rt = skvm_pkg::REQ_DELETE;
      end else begin
        rt = REQ_RESERVED;
      end
      send_req(rt, pick_key(use_fill), $urandom);
    end
    drain();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= skvm_pkg::CFG_ROOT_KEY;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= skvm_pkg::REQ_LOOKUP;
    req_if.key       <= '0;
    req_if.new_value <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'hFFFF_FFFE;
    key_pool[5] = 32'hFFFF_FFFF;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The root key is zero after reset, so key zero lookups bypass the table.
    send_req(skvm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h0000_0005, 32'h0000_0000);
    send_req(skvm_pkg::REQ_DELETE, 32'h0000_0005, 32'h0000_0000);
    send_req(skvm_pkg::REQ_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_ADD,    32'h8000_0000, 32'hFFFF_FFFF);
    send_req(skvm_pkg::REQ_ADD,    32'h7FFF_FFFF, 32'h0000_0000);
    send_req(skvm_pkg::REQ_ADD,    32'hFFFF_FFFF, 32'h1234_5678);
    send_req(skvm_pkg::REQ_ADD,    32'h0000_0001, 32'hA5A5_A5A5);
    send_req(skvm_pkg::REQ_ADD,    32'h0000_0000, 32'h5A5A_5A5A);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_ADD,    32'h8000_0000, 32'h0000_0001);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(REQ_RESERVED,         32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(skvm_pkg::REQ_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(skvm_pkg::REQ_DELETE, 32'h0000_0001, 32'h0000_0000);
    drain();

    set_root(32'h8000_0000, 32'hFFFF_FFFF);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_req(skvm_pkg::REQ_ADD,    32'h8000_0000, 32'h0000_0002);
    send_req(skvm_pkg::REQ_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    set_root(key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
    run_mixed(120, 35, 40, 20, 1'b0);

    // Ascending keys keep inserts cheap while the table grows.
    set_root(32'hFFFF_FFFF, 32'h0000_0000);
    for (int unsigned i = 0; i < FILL_COUNT; i++) begin
      fill_keys.push_back(32'h4000_0000 + i * 4096 + $urandom_range(0, 4095));
      send_req(skvm_pkg::REQ_ADD, fill_keys[$], $urandom);
    end
    drain();

    run_mixed(100, 30, 45, 20, 1'b1);

    set_root(fill_keys[$urandom_range(0, fill_keys.size() - 1)], $urandom);
    run_mixed(100, 30, 25, 40, 1'b1);

    repeat (1100) @(posedge clk_i);
    $display("Summary: %0d requests over %0d root settings: %0d lookup hits, %0d inserts,",
             sb.n_req, root_moves + 1, sb.n_hit, sb.n_insert);
    $display("Summary: %0d updates, %0d deletes, %0d adds refused, peak table %0d of %0d",
             sb.n_update, sb.n_delete, sb.n_full, sb.peak, skvm_pkg::CAPACITY);
    if (sb.errors == 0 && sb.pending_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d responses outstanding", sb.pending_rsp_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
